// ===== rtl/core/lbc_pkg.sv =====
`timescale 1ns / 1ps
package lbc_pkg;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int REPEAT_W = 20;
  localparam logic [REPEAT_W-1:0] REPEAT_MAX = '1;

  localparam int RUN_BITS_DEF = 16;
  localparam int TW_W         = 5;
  localparam logic [TW_W-1:0] TW_MAX = 5'd16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_TO_TAB     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAB_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONV_HEAD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONV_TAIL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FORCE_BLNK = 3'd4;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_EOS  = 1'b1;

endpackage

// ===== rtl/core/leading_trailing_blank_converter.sv =====
`timescale 1ns / 1ps
// Leading/trailing blank converter for a text byte stream.
// Input channel (in_valid/in_stall): kind selects a data byte or an
// end-of-stream flush; data_byte carries the text byte.
// Output channel (out_valid/out_stall): (out_byte, repeat_res) pairs, with
// last set on the final result of each input request. A request yields at
// most two results: the pending blank run, then the byte itself.
// Configuration: cfg_we/cfg_index/cfg_data write one register per cycle; the user
// must write only while the block is idle, which the block itself leaves unchecked.
// Sequencing: a blank byte only extends the pending run and yields nothing.
// Any other request produces its results in turn, after one multiply for a run
// converted to spaces, or after the one-bit-per-cycle restoring divider for a
// run converted to tabs.
// in_stall stays high from acceptance until the last result sits in the
// output register, so the next request can enter while it waits there.
// When the receiver stalls, the output register holds its result and the
// sequencer waits for it before loading the next result.
// Reset (rst, synchronous) restores the register defaults, returns to line
// start with an empty run and drops any pending output.
module leading_trailing_blank_converter
  import lbc_pkg::*;
#(
  parameter int RUN_BITS = RUN_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  kind,
  input  logic [7:0]            data_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_byte,
  output logic [REPEAT_W-1:0]   repeat_res,
  output logic                  last,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DW    = RUN_BITS + 1;
  localparam int PW    = RUN_BITS + TW_W;
  localparam int CW    = (PW > REPEAT_W) ? PW : REPEAT_W;
  localparam int CNT_W = $clog2(DW);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_RUN  = 3'd3;
  localparam logic [2:0] ST_BYTE = 3'd4;

  logic            to_tab, conv_head, conv_tail, force_blank;
  logic [TW_W-1:0] tab_width;
  logic [TW_W-1:0] w_eff;

  logic [2:0]          state;
  logic                in_body;
  logic [RUN_BITS-1:0] run_count;
  logic                has_byte;
  logic                body_next;
  logic                conv_sel;
  logic [7:0]          byte_q;
  logic [PW-1:0]       rep_acc;
  logic [DW-1:0]       dvd;
  logic [TW_W-1:0]     rem;
  logic [CNT_W-1:0]    cnt;

  logic                accept, out_free, out_load;
  logic [7:0]          blank;
  logic                end_conv, conv;
  logic [TW_W:0]       trial;
  logic                qbit;
  logic [TW_W-1:0]     rem_next;
  logic [DW-1:0]       dvd_next;
  logic [CW-1:0]       rep_wide;
  logic [REPEAT_W-1:0] rep_sat;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign out_load = ((state == ST_RUN) || (state == ST_BYTE)) && out_free;

  always_comb begin
    if (tab_width == '0) begin
      w_eff = TW_W'(1);
    end else if (tab_width > TW_MAX) begin
      w_eff = TW_MAX;
    end else begin
      w_eff = tab_width;
    end
  end

  assign blank    = to_tab ? CH_SPACE : CH_TAB;
  assign end_conv = in_body ? conv_tail : (conv_head && force_blank);

  // One restoring-division step: quotient bits shift into the dividend.
  assign trial    = {rem, dvd[DW-1]};
  assign qbit     = (trial >= {1'b0, w_eff});
  assign rem_next = qbit ? TW_W'(trial - {1'b0, w_eff}) : trial[TW_W-1:0];
  assign dvd_next = {dvd[DW-2:0], qbit};

  assign rep_wide = CW'(rep_acc);
  assign rep_sat  = (rep_wide > CW'(REPEAT_MAX)) ? REPEAT_MAX : rep_wide[REPEAT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      to_tab      <= 1'b1;
      tab_width   <= TW_W'(4);
      conv_head   <= 1'b1;
      conv_tail   <= 1'b0;
      force_blank <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TO_TAB:     to_tab      <= cfg_data[0];
        REG_TAB_WIDTH:  tab_width   <= cfg_data[TW_W-1:0];
        REG_CONV_HEAD:  conv_head   <= cfg_data[0];
        REG_CONV_TAIL:  conv_tail   <= cfg_data[0];
        REG_FORCE_BLNK: force_blank <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (kind == KIND_EOS || data_byte == CH_CR || data_byte == CH_LF) begin
      conv = end_conv;
    end else begin
      conv = !in_body && conv_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_body   <= 1'b0;
      run_count <= '0;
      out_valid <= 1'b0;
      has_byte  <= 1'b0;
      body_next <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            byte_q <= data_byte;
            if (kind == KIND_DATA && data_byte == blank) begin
              // saturate; extra blanks of a full run are dropped
              if (run_count != '1) begin
                run_count <= run_count + RUN_BITS'(1);
              end
            end else begin
              has_byte  <= (kind == KIND_DATA);
              body_next <= (kind == KIND_DATA) && data_byte != CH_CR && data_byte != CH_LF;
              conv_sel  <= conv;
              rep_acc   <= PW'(run_count);
              dvd       <= DW'(run_count) + DW'(w_eff) - DW'(1);
              rem       <= '0;
              cnt       <= '0;
              if (run_count == '0) begin
                if (kind == KIND_DATA) begin
                  state <= ST_BYTE;
                end else begin
                  in_body <= 1'b0;
                end
              end else if (!conv) begin
                state <= ST_RUN;
              end else if (to_tab) begin
                state <= ST_DIV;
              end else begin
                state <= ST_MUL;
              end
            end
          end
        end
        ST_MUL: begin
          rep_acc <= PW'(run_count) * PW'(w_eff);
          state   <= ST_RUN;
        end
        ST_DIV: begin
          dvd <= dvd_next;
          rem <= rem_next;
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(DW - 1)) begin
            rep_acc <= PW'(dvd_next);
            state   <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (out_free) begin
            // converted runs change the character, plain runs keep the blank
            if (!conv_sel) begin
              out_byte <= blank;
            end else if (to_tab) begin
              out_byte <= CH_TAB;
            end else begin
              out_byte <= CH_SPACE;
            end
            repeat_res <= rep_sat;
            last       <= !has_byte;
            if (has_byte) begin
              state <= ST_BYTE;
            end else begin
              state     <= ST_IDLE;
              in_body   <= 1'b0;
              run_count <= '0;
            end
          end
        end
        ST_BYTE: begin
          if (out_free) begin
            out_byte   <= byte_q;
            repeat_res <= REPEAT_W'(1);
            last       <= 1'b1;
            state      <= ST_IDLE;
            in_body    <= body_next;
            run_count  <= '0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> rem < w_eff)
    else $error("divider remainder reached tab width");

  a_rep_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> repeat_res != '0)
    else $error("result with zero repeat");

  a_byte_needs_data: assert property (@(posedge clk) disable iff (rst)
    state == ST_BYTE |-> has_byte)
    else $error("byte result for a flush request");

  a_run_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && $past(state) != ST_IDLE) |-> run_count == '0)
    else $error("pending run left after results");

endmodule
